### hdl/sfx_pkg.sv
// Shared codes, widths and control bytes for the serial buffering block.
`timescale 1ns / 1ps
package sfx_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned MARK_W     = 7;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = MARK_W;

  localparam logic [OP_W-1:0] OP_RESERVE = 2'd0;
  localparam logic [OP_W-1:0] OP_PUT     = 2'd1;
  localparam logic [OP_W-1:0] OP_GET     = 2'd2;
  localparam logic [OP_W-1:0] OP_TICK    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_XON_LOW   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_XOFF_HIGH = 1'b1;

  localparam logic [MARK_W-1:0] XON_LOW_RESET   = 7'd8;
  localparam logic [MARK_W-1:0] XOFF_HIGH_RESET = 7'd56;

  // Control characters: Ctrl-Q resumes, Ctrl-S pauses.
  localparam logic [BYTE_W-1:0] CTRL_NONE = 8'h00;
  localparam logic [BYTE_W-1:0] CTRL_XON  = 8'h11;
  localparam logic [BYTE_W-1:0] CTRL_XOFF = 8'h13;

endpackage

### hdl/sfx_in_if.sv
// Input channel: one operation beat with its operands and link status.
`timescale 1ns / 1ps
interface sfx_in_if import sfx_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [BYTE_W-1:0] data_byte;
  logic [BYTE_W-1:0] msg_len;
  logic              link_tx_ready;
  logic              link_rx_valid;
  logic [BYTE_W-1:0] link_rx_byte;

  modport source (output valid, operation, data_byte, msg_len, link_tx_ready,
                  link_rx_valid, link_rx_byte, input ready);
  modport sink (input valid, operation, data_byte, msg_len, link_tx_ready,
                link_rx_valid, link_rx_byte, output ready);
endinterface

### hdl/sfx_out_if.sv
// Output channel: one result beat per operation.
`timescale 1ns / 1ps
interface sfx_out_if import sfx_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              reserve_ok;
  logic [BYTE_W-1:0] granted_len;
  logic [BYTE_W-1:0] rx_byte;
  logic              send_valid;
  logic [BYTE_W-1:0] send_byte;

  modport source (output valid, reserve_ok, granted_len, rx_byte, send_valid,
                  send_byte, input ready);
  modport sink (input valid, reserve_ok, granted_len, rx_byte, send_valid,
                send_byte, output ready);
endinterface

### hdl/serial_fifos_with_xon_xoff.sv
// Top level: transmit and receive rings with XON/XOFF receive flow control.
//
//   channel   dir   handshake        contents
//   in_i      in    valid/ready      operation, data_byte, msg_len, link status, rx byte
//   out_o     out   valid/ready      reserve_ok, granted_len, rx_byte, send_valid, send_byte
//   cfg       in    cfg_we_i only    cfg_idx_i selects xon_low_mark / xoff_high_mark
//
// Reserve and put form their result directly; get and work tick pass through a read
// state, since they wait for the registered read of the receive or transmit ring memory.
// All pointer, flow and pending-control updates happen at the edge that accepts the
// beat; the read state only forms the result from the read data.
// A result waits in an output register; a new beat is accepted while it drains.
// Reset clears pointers, flow state, pending control and marks; ring contents stay
// undefined, and no clearing pass is needed.
`timescale 1ns / 1ps
module serial_fifos_with_xon_xoff import sfx_pkg::*; #(
  parameter int unsigned TX_DEPTH = 64,
  parameter int unsigned RX_DEPTH = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  sfx_in_if.sink                in_i,
  sfx_out_if.source             out_o
);

  localparam int unsigned TX_PTR_W = $clog2(TX_DEPTH);
  localparam int unsigned RX_PTR_W = $clog2(RX_DEPTH);
  localparam int unsigned TX_CMP_W = (TX_PTR_W > BYTE_W) ? TX_PTR_W : BYTE_W;
  localparam int unsigned RX_CMP_W = (RX_PTR_W > MARK_W) ? RX_PTR_W : MARK_W;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  function automatic logic [TX_PTR_W-1:0] tx_inc(input logic [TX_PTR_W-1:0] p);
    return (p == TX_PTR_W'(TX_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [RX_PTR_W-1:0] rx_inc(input logic [RX_PTR_W-1:0] p);
    return (p == RX_PTR_W'(RX_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [TX_PTR_W-1:0] tx_fill(input logic [TX_PTR_W-1:0] w,
                                                  input logic [TX_PTR_W-1:0] r);
    logic [TX_PTR_W:0] f;
    f = {1'b0, w} - {1'b0, r} + ((w < r) ? (TX_PTR_W+1)'(TX_DEPTH) : '0);
    return f[TX_PTR_W-1:0];
  endfunction

  function automatic logic [RX_PTR_W-1:0] rx_fill(input logic [RX_PTR_W-1:0] w,
                                                  input logic [RX_PTR_W-1:0] r);
    logic [RX_PTR_W:0] f;
    f = {1'b0, w} - {1'b0, r} + ((w < r) ? (RX_PTR_W+1)'(RX_DEPTH) : '0);
    return f[RX_PTR_W-1:0];
  endfunction

  // Control state.
  logic                state_q, state_d;
  logic [TX_PTR_W-1:0] tx_wr_q, tx_wr_d, tx_rd_q, tx_rd_d;
  logic [RX_PTR_W-1:0] rx_wr_q, rx_wr_d, rx_rd_q, rx_rd_d;
  logic                flow_on_q, flow_on_d;
  logic [BYTE_W-1:0]   pending_q, pending_d;
  logic [MARK_W-1:0]   xon_low_q, xoff_high_q;
  logic                out_valid_q, out_valid_d;

  // Context of a beat waiting on a ring read.
  logic [OP_W-1:0]   ctx_op_q, ctx_op_d;
  logic              ctx_hit_q, ctx_hit_d;
  logic              ctx_ctrl_q, ctx_ctrl_d;
  logic [BYTE_W-1:0] ctx_byte_q, ctx_byte_d;

  // Output payload.
  logic              res_ok_q, res_ok_d;
  logic [BYTE_W-1:0] res_len_q, res_len_d;
  logic [BYTE_W-1:0] res_rx_q, res_rx_d;
  logic              res_sv_q, res_sv_d;
  logic [BYTE_W-1:0] res_sb_q, res_sb_d;

  logic                in_fire;
  logic                out_fire;
  logic [TX_PTR_W-1:0] tx_space;
  logic [TX_PTR_W-1:0] tx_wr_inc;
  logic [RX_PTR_W-1:0] rx_wr_inc;
  logic [RX_PTR_W-1:0] rx_rd_after;
  logic [RX_PTR_W-1:0] rx_fill_after;
  logic                tx_empty, rx_empty;
  logic                tx_re, rx_re, tx_we, rx_we;
  logic [BYTE_W-1:0]   tx_rdata, rx_rdata;

  assign in_i.ready = (state_q == S_IDLE) && (!out_valid_q || out_o.ready);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = out_valid_q && out_o.ready;

  assign tx_empty  = (tx_wr_q == tx_rd_q);
  assign rx_empty  = (rx_wr_q == rx_rd_q);
  assign tx_space  = TX_PTR_W'(TX_DEPTH - 1) - tx_fill(tx_wr_q, tx_rd_q);
  assign tx_wr_inc = tx_inc(tx_wr_q);
  assign rx_wr_inc = rx_inc(rx_wr_q);
  assign rx_rd_after   = rx_empty ? rx_rd_q : rx_inc(rx_rd_q);
  assign rx_fill_after = rx_fill(rx_wr_q, rx_rd_after);

  assign tx_we = in_fire && (in_i.operation == OP_PUT);
  assign tx_re = in_fire && (in_i.operation == OP_TICK);
  assign rx_re = in_fire && (in_i.operation == OP_GET);
  assign rx_we = in_fire && (in_i.operation == OP_TICK) && in_i.link_rx_valid;

  sfx_ring_mem #(.DEPTH(TX_DEPTH)) u_tx_mem (
    .clk_i   (clk_i),
    .we_i    (tx_we),
    .waddr_i (tx_wr_q),
    .wdata_i (in_i.data_byte),
    .re_i    (tx_re),
    .raddr_i (tx_rd_q),
    .rdata_o (tx_rdata)
  );

  sfx_ring_mem #(.DEPTH(RX_DEPTH)) u_rx_mem (
    .clk_i   (clk_i),
    .we_i    (rx_we),
    .waddr_i (rx_wr_q),
    .wdata_i (in_i.link_rx_byte),
    .re_i    (rx_re),
    .raddr_i (rx_rd_q),
    .rdata_o (rx_rdata)
  );

  always_comb begin
    state_d     = state_q;
    tx_wr_d     = tx_wr_q;
    tx_rd_d     = tx_rd_q;
    rx_wr_d     = rx_wr_q;
    rx_rd_d     = rx_rd_q;
    flow_on_d   = flow_on_q;
    pending_d   = pending_q;
    out_valid_d = out_valid_q && !out_fire;
    ctx_op_d    = ctx_op_q;
    ctx_hit_d   = ctx_hit_q;
    ctx_ctrl_d  = ctx_ctrl_q;
    ctx_byte_d  = ctx_byte_q;
    res_ok_d    = res_ok_q;
    res_len_d   = res_len_q;
    res_rx_d    = res_rx_q;
    res_sv_d    = res_sv_q;
    res_sb_d    = res_sb_q;

    if (in_fire) begin
      ctx_op_d   = in_i.operation;
      ctx_hit_d  = 1'b0;
      ctx_ctrl_d = 1'b0;
      ctx_byte_d = pending_q;
      unique case (in_i.operation)
        OP_RESERVE: begin
          out_valid_d = 1'b1;
          res_ok_d    = (TX_CMP_W'(tx_space) >= TX_CMP_W'(in_i.msg_len));
          res_len_d   = res_ok_d ? in_i.msg_len : '0;
          res_rx_d    = '0;
          res_sv_d    = 1'b0;
          res_sb_d    = '0;
        end
        OP_PUT: begin
          tx_wr_d = tx_wr_inc;
          // A full ring loses its oldest byte.
          if (tx_wr_inc == tx_rd_q) begin
            tx_rd_d = tx_inc(tx_rd_q);
          end
          out_valid_d = 1'b1;
          res_ok_d    = 1'b0;
          res_len_d   = '0;
          res_rx_d    = '0;
          res_sv_d    = 1'b0;
          res_sb_d    = '0;
        end
        OP_GET: begin
          state_d   = S_READ;
          ctx_hit_d = !rx_empty;
          rx_rd_d   = rx_rd_after;
          if (!flow_on_q) begin
            if (RX_CMP_W'(rx_fill_after) < RX_CMP_W'(xon_low_q)) begin
              flow_on_d = 1'b1;
              pending_d = CTRL_XON;
            end
          end else begin
            if (RX_CMP_W'(rx_fill_after) > RX_CMP_W'(xoff_high_q)) begin
              flow_on_d = 1'b0;
              pending_d = CTRL_XOFF;
            end
          end
        end
        OP_TICK: begin
          state_d = S_READ;
          if (in_i.link_tx_ready) begin
            if (pending_q != CTRL_NONE) begin
              ctx_ctrl_d = 1'b1;
              pending_d  = CTRL_NONE;
            end else if (!tx_empty) begin
              ctx_hit_d = 1'b1;
              tx_rd_d   = tx_inc(tx_rd_q);
            end
          end
          if (in_i.link_rx_valid) begin
            rx_wr_d = rx_wr_inc;
            if (rx_wr_inc == rx_rd_q) begin
              rx_rd_d = rx_inc(rx_rd_q);
            end
          end
        end
        default: ;
      endcase
    end

    if (state_q == S_READ) begin
      state_d     = S_IDLE;
      out_valid_d = 1'b1;
      res_ok_d    = 1'b0;
      res_len_d   = '0;
      res_rx_d    = '0;
      res_sv_d    = 1'b0;
      res_sb_d    = '0;
      if (ctx_op_q == OP_GET) begin
        res_rx_d = ctx_hit_q ? rx_rdata : '0;
      end else if (ctx_ctrl_q) begin
        res_sv_d = 1'b1;
        res_sb_d = ctx_byte_q;
      end else if (ctx_hit_q && (tx_rdata != '0)) begin
        // A zero data byte leaves the ring but is not sent.
        res_sv_d = 1'b1;
        res_sb_d = tx_rdata;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tx_wr_q     <= '0;
      tx_rd_q     <= '0;
      rx_wr_q     <= '0;
      rx_rd_q     <= '0;
      flow_on_q   <= 1'b0;
      pending_q   <= CTRL_NONE;
      out_valid_q <= 1'b0;
      xon_low_q   <= XON_LOW_RESET;
      xoff_high_q <= XOFF_HIGH_RESET;
    end else begin
      state_q     <= state_d;
      tx_wr_q     <= tx_wr_d;
      tx_rd_q     <= tx_rd_d;
      rx_wr_q     <= rx_wr_d;
      rx_rd_q     <= rx_rd_d;
      flow_on_q   <= flow_on_d;
      pending_q   <= pending_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_XON_LOW:   xon_low_q   <= cfg_data_i;
          CFG_XOFF_HIGH: xoff_high_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ctx_op_q   <= ctx_op_d;
    ctx_hit_q  <= ctx_hit_d;
    ctx_ctrl_q <= ctx_ctrl_d;
    ctx_byte_q <= ctx_byte_d;
    res_ok_q   <= res_ok_d;
    res_len_q  <= res_len_d;
    res_rx_q   <= res_rx_d;
    res_sv_q   <= res_sv_d;
    res_sb_q   <= res_sb_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.reserve_ok  = res_ok_q;
  assign out_o.granted_len = res_len_q;
  assign out_o.rx_byte     = res_rx_q;
  assign out_o.send_valid  = res_sv_q;
  assign out_o.send_byte   = res_sb_q;

  // The output slot must be free while a ring read is outstanding.
  a_read_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> !out_valid_q)
    else $error("ring read outstanding while a result is still held");

  a_read_after_mem_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && ((in_i.operation == OP_GET) || (in_i.operation == OP_TICK)))
      |=> (state_q == S_READ))
    else $error("get or tick did not wait for the ring read");

  a_read_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |=> out_valid_q)
    else $error("ring read did not produce a result");

  a_pending_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pending_q == CTRL_NONE) || (pending_q == CTRL_XON) || (pending_q == CTRL_XOFF))
    else $error("pending control byte holds an unknown code");

  a_flow_on_queues_xon: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(flow_on_q) |-> (pending_q == CTRL_XON))
    else $error("entering XON state did not queue XON");

  a_flow_off_queues_xoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(flow_on_q) |-> (pending_q == CTRL_XOFF))
    else $error("entering XOFF state did not queue XOFF");

endmodule

### hdl/sfx_ring_mem.sv
// Byte-wide ring storage: one write port, one read port with registered data.
`timescale 1ns / 1ps
module sfx_ring_mem import sfx_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [BYTE_W-1:0]        wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [BYTE_W-1:0]        rdata_o
);

  logic [BYTE_W-1:0] mem_q [DEPTH];
  logic [BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
